// ===== hdl/perceptron_branch_predictor_defines.svh =====
// Assertion macros shared by the perceptron predictor RTL.
// Each macro expects the enclosing module to have clk and arst_n in scope.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PBP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define PBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PBP_ASSERT_IMPL(label, ante, cons, msg)
`define PBP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/pbp_pkg.sv =====
package pbp_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned NUM_ROWS_DEF    = 256;
	localparam int unsigned HISTORY_LEN_DEF = 15;

	// Fixed field widths.
	localparam int unsigned PC_W       = 32;
	localparam int unsigned WEIGHT_W   = 8;
	localparam int unsigned SUM_OUT_W  = 12;
	localparam int unsigned THR_W      = 7;
	localparam int unsigned THR_MAX    = (1 << THR_W) - 1;
	localparam int unsigned THR_RESET_DEF = 42;

	// Number of weights summed by one first-level adder chain.
	localparam int unsigned GROUP_SIZE = 8;

	typedef enum logic {
		CMD_PREDICT = 1'b0,
		CMD_TRAIN   = 1'b1
	} cmd_e;

	typedef logic [THR_W-1:0] thr_t;

	typedef struct packed {
		logic            cmd;
		logic [PC_W-1:0] pc;
		logic            outcome;
	} pbp_in_t;

	typedef struct packed {
		logic                        predict_taken;
		logic signed [SUM_OUT_W-1:0] perceptron_sum;
		logic                        mispredicted;
		logic                        weights_updated;
	} pbp_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd_row;
		logic part;
		logic total;
		logic wb;
		logic clr_step;
	} pbp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
	} pbp_stat_t;

endpackage

// ===== hdl/pbp_stream_if.sv =====
interface pbp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pbp_datapath.sv =====
module pbp_datapath #(
	parameter int unsigned NUM_ROWS    = pbp_pkg::NUM_ROWS_DEF,
	parameter int unsigned HISTORY_LEN = pbp_pkg::HISTORY_LEN_DEF,
	parameter pbp_pkg::thr_t THR_RESET = pbp_pkg::thr_t'(pbp_pkg::THR_RESET_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pbp_pkg::pbp_ctrl_t ctrl,
	output pbp_pkg::pbp_stat_t stat,
	input  pbp_pkg::pbp_in_t   in_data,
	input  logic               cfg_wr,
	input  pbp_pkg::thr_t      cfg_data,
	output pbp_pkg::pbp_out_t  out_data
);

	localparam int unsigned IDX_W    = $clog2(NUM_ROWS);
	localparam int unsigned NUM_W    = HISTORY_LEN + 1;
	localparam int unsigned WW       = pbp_pkg::WEIGHT_W;
	localparam int unsigned ROW_BITS = NUM_W * WW;
	localparam int unsigned NUM_GRP  = (NUM_W + pbp_pkg::GROUP_SIZE - 1) / pbp_pkg::GROUP_SIZE;
	localparam int unsigned NUM_PAD  = NUM_GRP * pbp_pkg::GROUP_SIZE;
	localparam int unsigned TERM_W   = WW + 1;
	localparam int unsigned PART_W   = TERM_W + $clog2(pbp_pkg::GROUP_SIZE);
	localparam int unsigned SUM_W    = PART_W + $clog2(NUM_GRP);
	localparam int unsigned OUT_W    = pbp_pkg::SUM_OUT_W;
	localparam int unsigned THR_W    = pbp_pkg::THR_W;

	// floor(2^32 / NUM_ROWS); the quotient estimate is at most one low.
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_ROWS);
	localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(NUM_ROWS);
	localparam logic [IDX_W-1:0] N_LAST = IDX_W'(NUM_ROWS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (OUT_W - 1)));

	// Item registers.
	logic             cmd_q;
	logic             outcome_q;
	logic [IDX_W:0]   pc_low_q;
	logic [IDX_W:0]   quo_low_q;
	logic [IDX_W-1:0] row_q;

	// State.
	logic [HISTORY_LEN-1:0] hist_q;
	pbp_pkg::thr_t          thr_q;
	logic [IDX_W-1:0]       clr_cnt_q;

	logic [ROW_BITS-1:0] wgt_mem_q [NUM_ROWS];
	logic [ROW_BITS-1:0] rd_row_q;

	logic signed [PART_W-1:0] part_q [NUM_GRP];
	logic signed [SUM_W-1:0]  sum_q;
	pbp_pkg::pbp_out_t        out_q;

	// Row index from the quotient estimate.
	logic [63:0]            prod;
	logic [2*IDX_W+1:0]     quo_n;
	logic [IDX_W:0]         rem_raw;
	logic [IDX_W-1:0]       row_idx;

	assign prod    = 64'(in_data.pc) * 64'(RECIP);
	assign quo_n   = quo_low_q * N_EXT;
	assign rem_raw = pc_low_q - quo_n[IDX_W:0];

	always_comb begin
		if (rem_raw >= N_EXT) begin
			row_idx = IDX_W'(rem_raw - N_EXT);
		end else begin
			row_idx = rem_raw[IDX_W-1:0];
		end
	end

	// Signed terms of the dot product, padded with zeros to whole groups.
	logic signed [TERM_W-1:0] term [NUM_PAD];
	logic signed [PART_W-1:0] part_d [NUM_GRP];
	logic [ROW_BITS-1:0]      new_row;

	for (genvar j = 0; j < NUM_PAD; j++) begin : g_term
		if (j == 0) begin : g_bias
			assign term[j] = TERM_W'(signed'(rd_row_q[WW-1:0]));
		end else if (j < NUM_W) begin : g_hist
			logic signed [TERM_W-1:0] w9;
			assign w9      = TERM_W'(signed'(rd_row_q[j*WW +: WW]));
			assign term[j] = hist_q[j-1] ? w9 : -w9;
		end else begin : g_pad
			assign term[j] = '0;
		end
	end

	for (genvar g = 0; g < NUM_GRP; g++) begin : g_part
		always_comb begin
			logic signed [PART_W-1:0] acc;
			acc = '0;
			for (int k = 0; k < pbp_pkg::GROUP_SIZE; k++) begin
				acc = acc + term[g*pbp_pkg::GROUP_SIZE + k];
			end
			part_d[g] = acc;
		end
	end

	logic signed [SUM_W-1:0] sum_d;

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			sum_d = sum_d + part_q[g];
		end
	end

	// Decision and training on the finished sum.
	logic             train;
	logic             pred;
	logic             mis;
	logic             upd;
	logic [SUM_W-1:0] abs_sum;
	logic [OUT_W-1:0] sum_sat;

	assign train   = (cmd_q == pbp_pkg::CMD_TRAIN);
	assign pred    = !sum_q[SUM_W-1];
	assign abs_sum = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mis     = train && (pred != outcome_q);
	assign upd     = train && (mis || (abs_sum <= SUM_W'(thr_q)));

	always_comb begin
		if (sum_q > SAT_HI) begin
			sum_sat = SAT_HI[OUT_W-1:0];
		end else if (sum_q < SAT_LO) begin
			sum_sat = SAT_LO[OUT_W-1:0];
		end else begin
			sum_sat = sum_q[OUT_W-1:0];
		end
	end

	for (genvar j = 0; j < NUM_W; j++) begin : g_nudge
		logic              up;
		logic signed [WW:0] nv;
		logic [WW:0]       abs_nv;
		if (j == 0) begin : g_bias_dir
			assign up = outcome_q;
		end else begin : g_hist_dir
			assign up = (hist_q[j-1] == outcome_q);
		end
		assign nv     = (WW + 1)'(signed'(rd_row_q[j*WW +: WW])) + (up ? 9'sd1 : -9'sd1);
		assign abs_nv = nv[WW] ? -nv : nv;
		assign new_row[j*WW +: WW] = (abs_nv < (WW + 1)'(thr_q)) ? nv[WW-1:0]
			: rd_row_q[j*WW +: WW];
	end

	// Weight memory: one row per access, read data registered.
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ROW_BITS-1:0] wr_data;

	assign wr_en   = ctrl.clr_step || (ctrl.wb && upd);
	assign wr_addr = ctrl.clr_step ? clr_cnt_q : row_q;
	assign wr_data = ctrl.clr_step ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wgt_mem_q[wr_addr] <= wr_data;
		end
		if (ctrl.rd_row) begin
			rd_row_q <= wgt_mem_q[row_idx];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= in_data.cmd;
			outcome_q <= in_data.outcome;
			pc_low_q  <= in_data.pc[IDX_W:0];
			quo_low_q <= prod[32 +: IDX_W + 1];
		end
		if (ctrl.rd_row) begin
			row_q <= row_idx;
		end
		if (ctrl.part) begin
			part_q <= part_d;
		end
		if (ctrl.total) begin
			sum_q <= sum_d;
		end
		if (ctrl.wb) begin
			out_q.predict_taken   <= pred;
			out_q.perceptron_sum  <= sum_sat;
			out_q.mispredicted    <= mis;
			out_q.weights_updated <= upd;
		end
	end

	// Control state: history, threshold and clear counter.
	logic [HISTORY_LEN:0] hist_ext;
	assign hist_ext = {hist_q, outcome_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= '0;
			thr_q     <= THR_RESET;
			clr_cnt_q <= '0;
		end else begin
			if (ctrl.wb && train) begin
				hist_q <= hist_ext[HISTORY_LEN-1:0];
			end
			if (cfg_wr) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (ctrl.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign stat.clr_last = (clr_cnt_q == N_LAST);
	assign out_data      = out_q;

endmodule

// ===== hdl/pbp_ctrl.sv =====
`include "perceptron_branch_predictor_defines.svh"

module pbp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pbp_pkg::pbp_stat_t stat,
	output pbp_pkg::pbp_ctrl_t ctrl
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ADDR  = 6'b000100,
		ST_PART  = 6'b001000,
		ST_TOTAL = 6'b010000,
		ST_WB    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   wb_fire;
	logic   in_fire;

	// The result register is free when empty or being emptied this cycle.
	assign out_free = !out_valid_q || out_ready;
	assign wb_fire  = (state_q == ST_WB) && out_free;
	assign in_ready = (state_q == ST_IDLE) || wb_fire;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR:  state_d = ST_PART;
			ST_PART:  state_d = ST_TOTAL;
			ST_TOTAL: state_d = ST_WB;
			ST_WB: begin
				if (wb_fire) begin
					state_d = in_fire ? ST_ADDR : ST_IDLE;
				end
			end
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign ctrl.load     = in_fire;
	assign ctrl.rd_row   = (state_q == ST_ADDR);
	assign ctrl.part     = (state_q == ST_PART);
	assign ctrl.total    = (state_q == ST_TOTAL);
	assign ctrl.wb       = wb_fire;
	assign ctrl.clr_step = (state_q == ST_CLEAR);

	`PBP_ASSERT_IMPL(a_no_accept_in_clear, state_q == ST_CLEAR, !in_ready, "item accepted during clear")
	`PBP_ASSERT_NEXT(a_accept_to_addr, in_fire, state_q == ST_ADDR, "accepted item did not start")
	`PBP_ASSERT_NEXT(a_wb_sets_result, wb_fire, out_valid_q, "write back left no result")

endmodule

// ===== hdl/perceptron_branch_predictor.sv =====
// Channel  Role    Payload                                           Handshake
// req      sink    cmd, pc, outcome                                  valid/ready
// rsp      source  predict_taken, perceptron_sum, mispredicted,      valid/ready
//                  weights_updated
// cfg      sink    train_threshold (7 bits)                          valid/ready
//
// An item passes from its accept edge to its result through row index and registered
// row read, partial sums, final sum, then decision and write back; the registered read
// and the two-level adder tree set these steps. The next request is taken in the
// write-back cycle, so a new item starts while the last is written back; write back waits
// only while the previous result is still not taken. After reset a clearing pass zeroes
// every weight row with req held off. Configuration writes are taken in every cycle.
module perceptron_branch_predictor #(
	parameter int unsigned NUM_ROWS    = pbp_pkg::NUM_ROWS_DEF,
	parameter int unsigned HISTORY_LEN = pbp_pkg::HISTORY_LEN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	pbp_stream_if.sink   req,
	pbp_stream_if.source rsp,
	pbp_stream_if.sink   cfg
);

	// The threshold resets to floor(1.93 * HISTORY_LEN + 14), capped at the
	// largest value of the register.
	localparam int unsigned THR_CALC = (193 * HISTORY_LEN + 1400) / 100;
	localparam pbp_pkg::thr_t THR_RESET = (pbp_pkg::THR_W)'(
		(THR_CALC > pbp_pkg::THR_MAX) ? pbp_pkg::THR_MAX : THR_CALC);

	pbp_pkg::pbp_ctrl_t ctrl;
	pbp_pkg::pbp_stat_t stat;

	// The controller sequences one item at a time and owns the result valid flag.
	pbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// The datapath holds the weight memory, history, threshold and result payload.
	pbp_datapath #(
		.NUM_ROWS    (NUM_ROWS),
		.HISTORY_LEN (HISTORY_LEN),
		.THR_RESET   (THR_RESET)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.in_data  (req.data),
		.cfg_wr   (cfg.valid),
		.cfg_data (cfg.data),
		.out_data (rsp.data)
	);

	// The threshold register accepts a write transaction in any cycle.
	assign cfg.ready = 1'b1;

endmodule

// ===== sim/tb_perceptron_branch_predictor.sv =====
`timescale 1ns / 100ps

module tb_perceptron_branch_predictor;
	import pbp_pkg::*;

	localparam int unsigned NUM_ROWS    = NUM_ROWS_DEF;
	localparam int unsigned HISTORY_LEN = HISTORY_LEN_DEF;
	localparam int          SUM_HI      = 2047;
	localparam int          SUM_LO      = -2048;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 100;
	localparam int          HOT_COUNT   = 4;

	logic clk;
	logic arst_n;

	pbp_stream_if #(.payload_t(pbp_in_t))  req_if ();
	pbp_stream_if #(.payload_t(pbp_out_t)) rsp_if ();
	pbp_stream_if #(.payload_t(thr_t))     cfg_if ();

	perceptron_branch_predictor #(
		.NUM_ROWS   (NUM_ROWS),
		.HISTORY_LEN(HISTORY_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	// Shadow copy of the predictor state. The weight rows, the global history and
	// the threshold are advanced at the edge that accepts each transaction.
	logic signed [WEIGHT_W-1:0] row_weights [NUM_ROWS][HISTORY_LEN+1];
	logic [HISTORY_LEN-1:0]     ghist;
	thr_t                       thr_model;

	// Predictions waiting for their response transaction, oldest first.
	pbp_out_t expected_q [$];

	int mismatch_count;
	int cycle_count;

	// Idle percentages for the sender and the receiver, changed between phases.
	int gap_pct;
	int stall_pct;

	// Hot branches of the random stream: each one follows a loop pattern of its own.
	logic [PC_W-1:0] hot_pc     [HOT_COUNT];
	int              hot_period [HOT_COUNT];
	int              hot_iter   [HOT_COUNT];

	always #4 clk = ~clk;

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Computes the response to one request and applies any training it causes.
	// The sum is formed from the weights before the update, and the decisions
	// use the exact sum; only the output field is saturated.
	function automatic pbp_out_t predict_branch(input pbp_in_t t);
		int unsigned row;
		int          acc;
		int          nv;
		int          i;
		int          limit;
		logic        taken;
		logic        wrong;
		logic        trained;
		pbp_out_t    r;
		row     = t.pc % NUM_ROWS;
		limit   = int'(thr_model);
		acc     = int'(row_weights[row][0]);
		for (i = 1; i <= HISTORY_LEN; i++) begin
			if (ghist[i-1]) begin
				acc += int'(row_weights[row][i]);
			end else begin
				acc -= int'(row_weights[row][i]);
			end
		end
		taken   = (acc >= 0);
		wrong   = 1'b0;
		trained = 1'b0;
		if (t.cmd == CMD_TRAIN) begin
			wrong = (taken != t.outcome);
			if (wrong || magnitude(acc) <= limit) begin
				trained = 1'b1;
				// A weight steps toward agreement only if it stays strictly inside
				// the threshold; otherwise it keeps its value.
				nv = int'(row_weights[row][0]) + (t.outcome ? 1 : -1);
				if (magnitude(nv) < limit) begin
					row_weights[row][0] = WEIGHT_W'(nv);
				end
				for (i = 1; i <= HISTORY_LEN; i++) begin
					nv = int'(row_weights[row][i]) + ((ghist[i-1] == t.outcome) ? 1 : -1);
					if (magnitude(nv) < limit) begin
						row_weights[row][i] = WEIGHT_W'(nv);
					end
				end
			end
			ghist = {ghist[HISTORY_LEN-2:0], t.outcome};
		end
		r.predict_taken   = taken;
		r.perceptron_sum  = SUM_OUT_W'((acc > SUM_HI) ? SUM_HI : ((acc < SUM_LO) ? SUM_LO : acc));
		r.mispredicted    = wrong;
		r.weights_updated = trained;
		return r;
	endfunction

	// Scoreboard. A response accepted at the same edge as a request always belongs
	// to an earlier request, so it is checked before the new prediction is queued.
	always @(posedge clk) begin
		pbp_out_t want;
		pbp_out_t got;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				if (expected_q.size() == 0) begin
					$error("response transaction with no request pending");
					mismatch_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.predict_taken !== want.predict_taken) begin
						$error("predict_taken: expected %0d, got %0d",
							want.predict_taken, got.predict_taken);
						mismatch_count++;
					end
					if (got.perceptron_sum !== want.perceptron_sum) begin
						$error("perceptron_sum: expected %0d, got %0d",
							$signed(want.perceptron_sum), $signed(got.perceptron_sum));
						mismatch_count++;
					end
					if (got.mispredicted !== want.mispredicted) begin
						$error("mispredicted: expected %0d, got %0d",
							want.mispredicted, got.mispredicted);
						mismatch_count++;
					end
					if (got.weights_updated !== want.weights_updated) begin
						$error("weights_updated: expected %0d, got %0d",
							want.weights_updated, got.weights_updated);
						mismatch_count++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				expected_q.push_back(predict_branch(req_if.data));
			end
			if (cfg_if.valid && cfg_if.ready) begin
				thr_model = cfg_if.data;
			end
		end
	end

	// Watchdog: the slowest correct run is far below this count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: ready drops in bursts of random length.
	initial begin
		int hold;
		hold = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				rsp_if.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(1, 10) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Sends one request transaction, after a random gap when the sender is idling.
	// Valid is left high so back-to-back requests keep it up.
	task automatic send_item(input cmd_e c, input logic [PC_W-1:0] addr, input logic dir);
		int      gap;
		pbp_in_t t;
		gap = 0;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 10);
		end
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.cmd     = c;
		t.pc      = addr;
		t.outcome = dir;
		req_if.data  <= t;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// Holds off requests until every queued prediction has been answered.
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
	endtask

	task automatic write_threshold(input thr_t value);
		cfg_if.data  <= value;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// After reset every row is zero, so each prediction has a sum of zero and is
	// taken. The outcome field must be ignored on a predict request.
	task automatic test_cleared_store();
		send_item(CMD_PREDICT, '0, 1'b1);
		send_item(CMD_PREDICT, '1, 1'b0);
		send_item(CMD_PREDICT, 32'h0000_0100, 1'b1);
	endtask

	// With a threshold of 2 every weight is limited to -1..1, so repeated training
	// of one row quickly hits the bound, and the row still reports an update.
	// Address 0x105 aliases row 5.
	task automatic test_training_steps();
		wait_for_results();
		write_threshold(7'd2);
		send_item(CMD_TRAIN, 32'd5, 1'b0);
		send_item(CMD_TRAIN, 32'd5, 1'b0);
		send_item(CMD_TRAIN, 32'd5, 1'b1);
		send_item(CMD_TRAIN, 32'h0000_0105, 1'b1);
		send_item(CMD_TRAIN, 32'd5, 1'b1);
		send_item(CMD_PREDICT, 32'd5, 1'b0);
		send_item(CMD_TRAIN, 32'd5, 1'b0);
	endtask

	// A threshold of zero or one lets no weight move, yet training still fires on
	// a misprediction or a zero sum. Then weights are grown under the widest
	// threshold, and the threshold is lowered beneath them: they must keep their
	// values, since neither step brings them back inside.
	task automatic test_threshold_extremes();
		wait_for_results();
		write_threshold(7'd0);
		send_item(CMD_TRAIN, 32'd9, 1'b0);
		send_item(CMD_TRAIN, 32'd9, 1'b1);
		send_item(CMD_PREDICT, 32'd9, 1'b1);
		wait_for_results();
		write_threshold(7'd1);
		send_item(CMD_TRAIN, 32'd9, 1'b0);
		send_item(CMD_TRAIN, 32'd9, 1'b1);
		wait_for_results();
		write_threshold(7'(THR_MAX));
		repeat (5) send_item(CMD_TRAIN, 32'd20, 1'b1);
		wait_for_results();
		write_threshold(7'd3);
		send_item(CMD_TRAIN, 32'd20, 1'b1);
		send_item(CMD_TRAIN, 32'd20, 1'b0);
		send_item(CMD_PREDICT, 32'd20, 1'b0);
	endtask

	// Random stream in phases, each under its own threshold and idle mix. Most
	// requests train a few hot branches that follow loop patterns, so their
	// weights grow and the sums leave the training margin; the rest are predicts
	// and requests with random fields. The hot branches persist across phases,
	// so a lowered threshold meets weights already beyond it. The last phase
	// runs with no idling on either side.
	task automatic test_random_stream();
		int   thr_plan [PHASES];
		int   p;
		int   n;
		int   sel;
		int   h;
		logic dir;
		cmd_e c;
		thr_plan = '{127, 1, -1, 42, -1, 127, 3, 42};
		for (h = 0; h < HOT_COUNT; h++) begin
			hot_pc[h]     = $urandom();
			hot_period[h] = $urandom_range(2, 8);
			hot_iter[h]   = 0;
		end
		for (p = 0; p < PHASES; p++) begin
			wait_for_results();
			// A negative entry in the plan picks a random in-range threshold.
			if (thr_plan[p] < 0) begin
				write_threshold(7'($urandom_range(1, THR_MAX)));
			end else begin
				write_threshold(7'(thr_plan[p]));
			end
			if (p == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 20 * $urandom_range(0, 2);
				stall_pct = 20 * $urandom_range(0, 2);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					h   = $urandom_range(0, HOT_COUNT - 1);
					// Loop branch: taken except on the last iteration of its period.
					dir = (hot_iter[h] % hot_period[h]) != (hot_period[h] - 1);
					hot_iter[h]++;
					send_item(CMD_TRAIN, hot_pc[h], dir);
				end else if (sel < 80) begin
					h = $urandom_range(0, HOT_COUNT - 1);
					send_item(CMD_PREDICT, hot_pc[h], 1'($urandom_range(0, 1)));
				end else begin
					c = $urandom_range(0, 1) ? CMD_TRAIN : CMD_PREDICT;
					send_item(c, $urandom(), 1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	initial begin
		int r;
		int i;
		clk            = 1'b0;
		cycle_count    = 0;
		mismatch_count = 0;
		gap_pct        = 0;
		stall_pct      = 0;
		for (r = 0; r < NUM_ROWS; r++) begin
			for (i = 0; i <= HISTORY_LEN; i++) begin
				row_weights[r][i] = '0;
			end
		end
		ghist     = '0;
		thr_model = 7'(THR_RESET_DEF);

		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed part runs with moderate idling on both sides.
		gap_pct   = 25;
		stall_pct = 25;
		test_cleared_store();
		test_training_steps();
		test_threshold_extremes();
		test_random_stream();

		// Every request has been accepted; let the last responses drain, then
		// allow the block's latency before judging.
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== perceptron_branch_predictor.f =====
+incdir+hdl
hdl/pbp_pkg.sv
hdl/pbp_stream_if.sv
hdl/pbp_datapath.sv
hdl/pbp_ctrl.sv
hdl/perceptron_branch_predictor.sv
sim/tb_perceptron_branch_predictor.sv
